>>> hw/rtl/k_mismatch_pattern_search_assert.svh
// Assertion macros used by the port-level checker of the pattern search block.
`ifndef K_MISMATCH_PATTERN_SEARCH_ASSERT_SVH
`define K_MISMATCH_PATTERN_SEARCH_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define KMPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define KMPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/kmps_pkg.sv
// Shared types and constants of the k-mismatch pattern search block.
package kmps_pkg;

  localparam int OP_W  = 2;
  localparam int SYM_W = 8;
  localparam int POS_W = 17;
  localparam int MM_W  = 4;
  localparam int CNT_W = 5;

  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
  localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;
  localparam logic [OP_W-1:0] OP_END     = 2'd3;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [MM_W-1:0] MM_RESET = 4'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic pat_wr;
    logic text_start;
    logic step;
    logic finish;
    logic sum_hold;
    logic out_load;
  } kmps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic text_ok;
    logic last_iter;
    logic match;
    logic out_free;
  } kmps_stat_t;

endpackage

>>> hw/rtl/kmps_item_if.sv
// Input item channel: operation code and symbol with valid/ready.
interface kmps_item_if import kmps_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, op, symbol, input ready);
  modport sink (input valid, op, symbol, output ready);
endinterface

>>> hw/rtl/kmps_report_if.sv
// Result channel: match report or end-of-text summary with valid/ready.
interface kmps_report_if import kmps_pkg::*;;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [POS_W-1:0] position;
  logic             found_none;

  modport source (output valid, kind, position, found_none, input ready);
  modport sink (input valid, kind, position, found_none, output ready);
endinterface

>>> hw/rtl/kmps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmps_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read returns the old word on a same-address collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/kmps_ctrl.sv
// Controller state machine: sequences items through the datapath.
module kmps_ctrl import kmps_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic [OP_W-1:0] item_op,
  output logic            item_ready,
  input  kmps_stat_t      stat,
  output kmps_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  // Decode the next state and the datapath commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item_op)
            OP_CLEAR:   cmd.clear = 1'b1;
            OP_PATTERN: cmd.pat_wr = 1'b1;
            OP_TEXT: begin
              if (stat.text_ok) begin
                cmd.text_start = 1'b1;
                state_next     = S_RUN;
              end
            end
            OP_END: begin
              cmd.sum_hold = 1'b1;
              state_next   = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (stat.last_iter) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.finish = 1'b1;
        state_next = stat.match ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/kmps_dp.sv
// Datapath: pattern and counter memories, case registers, result register.
module kmps_dp import kmps_pkg::*; #(
  parameter int MAX_PATTERN = 1024,
  parameter int MAX_TEXT    = 131072
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [MM_W-1:0]  cfg_wr_data,
  input  logic [SYM_W-1:0] item_symbol,
  input  kmps_cmd_t        cmd,
  output kmps_stat_t       stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [POS_W-1:0] out_position,
  output logic             out_found_none
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int TW = $clog2(MAX_TEXT + 1);
  localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_PATTERN);
  localparam logic [TW-1:0] TEXT_MAX = TW'(MAX_TEXT);

  logic [MM_W-1:0]  max_mismatch;
  logic [LW-1:0]    len;
  logic [TW-1:0]    tpos;
  logic [AW-1:0]    tmod;
  logic             any_match;
  logic [SYM_W-1:0] sym;
  logic [AW-1:0]    j;
  logic [AW-1:0]    slot;
  logic             wb_valid;
  logic             wb_first;
  logic             wb_last;
  logic [AW-1:0]    wb_slot;
  logic             res_kind;
  logic [POS_W-1:0] res_pos;

  logic [SYM_W-1:0] pat_rd;
  logic [CNT_W-1:0] cnt_rd;
  logic [CNT_W-1:0] cnt_old;
  logic [CNT_W-1:0] cnt_new;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] mm_ext;
  logic [LW-1:0]    len_m1;
  logic             pat_we;
  logic             last_iter;
  logic             window_full;
  logic             match;
  logic [31:0]      start_pos;

  assign len_m1      = len - LW'(1);
  assign pat_we      = cmd.pat_wr && (tpos == '0) && (len < LEN_MAX);
  assign last_iter   = (LW'(j) == len_m1) || (32'(j) == 32'(tpos));
  assign window_full = (32'(tpos) + 32'd1) >= 32'(len);
  assign start_pos   = 32'(tpos) + 32'd1 - 32'(len);

  // Update one alignment counter; a fresh alignment starts from zero.
  assign mm_ext  = CNT_W'(max_mismatch);
  assign limit   = mm_ext + CNT_W'(1);
  assign cnt_old = wb_first ? '0 : cnt_rd;
  assign cnt_new = ((sym != pat_rd) && (cnt_old < limit)) ? cnt_old + CNT_W'(1) : cnt_old;
  assign match   = wb_valid && wb_last && window_full && (cnt_new <= mm_ext);

  assign stat.text_ok   = (len != '0) && (tpos < TEXT_MAX);
  assign stat.last_iter = last_iter;
  assign stat.match     = match;
  assign stat.out_free  = !out_valid || out_ready;

  kmps_ram #(
    .WIDTH  (SYM_W),
    .DEPTH  (MAX_PATTERN),
    .ADDR_W (AW)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (len[AW-1:0]),
    .wdata (item_symbol),
    .raddr (j),
    .rdata (pat_rd)
  );

  kmps_ram #(
    .WIDTH  (CNT_W),
    .DEPTH  (MAX_PATTERN),
    .ADDR_W (AW)
  ) u_count_ram (
    .clk   (clk),
    .we    (wb_valid),
    .waddr (wb_slot),
    .wdata (cnt_new),
    .raddr (slot),
    .rdata (cnt_rd)
  );

  // Hold the case state: register, lengths, position, match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_mismatch <= MM_RESET;
      len          <= '0;
      tpos         <= '0;
      tmod         <= '0;
      any_match    <= 1'b0;
      wb_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_mismatch <= cfg_wr_data;
      end
      if (cmd.clear) begin
        len       <= '0;
        tpos      <= '0;
        tmod      <= '0;
        any_match <= 1'b0;
      end
      if (pat_we) begin
        len <= len + LW'(1);
      end
      if (cmd.finish) begin
        tpos      <= tpos + TW'(1);
        tmod      <= ((LW'(tmod) + LW'(1)) == len) ? '0 : tmod + AW'(1);
        any_match <= any_match || match;
      end
      wb_valid <= cmd.step;
      // Load the result register, drop it once transferred.
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Advance the alignment loop and the write-back stage; load the result and output registers.
  always_ff @(posedge clk) begin
    if (cmd.text_start) begin
      sym  <= item_symbol;
      j    <= '0;
      slot <= tmod;
    end else if (cmd.step) begin
      j    <= j + AW'(1);
      slot <= (slot == '0) ? AW'(len_m1) : slot - AW'(1);
    end
    wb_first <= (j == '0);
    wb_last  <= last_iter;
    wb_slot  <= slot;
    if (cmd.finish) begin
      res_kind <= KIND_MATCH;
      res_pos  <= start_pos[POS_W-1:0];
    end else if (cmd.sum_hold) begin
      res_kind <= KIND_SUMMARY;
      res_pos  <= '0;
    end
    if (cmd.out_load) begin
      out_kind       <= res_kind;
      out_position   <= res_pos;
      out_found_none <= (res_kind == KIND_SUMMARY) && !any_match;
    end
  end

endmodule

>>> hw/rtl/k_mismatch_pattern_search.sv
// Top level of the k-mismatch pattern search block.
//
//   channel   direction  payload                          transfer when
//   item      in         op[1:0], symbol[7:0]             valid && ready
//   report    out        kind, position[16:0], found_none valid && ready
//   cfg       in         cfg_wr_data[3:0] (max_mismatch)  cfg_wr_en
//
// Clear, pattern byte and ignored text bytes are taken in the idle state; end of
// text passes the emit state. A text byte at position t updates min(len, t+1)
// alignments in the run state, then passes the drain state and, on a match, the
// emit state: the counter memory has one read and one write port, so one alignment
// is updated per cycle. Reset is synchronous; counters need no clearing pass since each
// alignment's counter is zeroed when that alignment starts.
// A stalled report holds in the output register; a new report waits for it.
module k_mismatch_pattern_search import kmps_pkg::*; #(
  parameter int MAX_PATTERN = 1024,
  parameter int MAX_TEXT    = 131072
) (
  input  logic              clk,
  input  logic              rst,
  kmps_item_if.sink         item,
  kmps_report_if.source     report,
  input  logic              cfg_wr_en,
  input  logic [MM_W-1:0]   cfg_wr_data
);

  kmps_cmd_t  cmd;
  kmps_stat_t stat;

  kmps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_op    (item.op),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  kmps_dp #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .item_symbol    (item.symbol),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (report.valid),
    .out_ready      (report.ready),
    .out_kind       (report.kind),
    .out_position   (report.position),
    .out_found_none (report.found_none)
  );

endmodule

>>> hw/rtl/kmps_checker.sv
// Port-level checker for the pattern search block and its bind.
`include "k_mismatch_pattern_search_assert.svh"

module kmps_port_props import kmps_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic [OP_W-1:0]  item_op,
  input logic             report_valid,
  input logic             report_ready,
  input logic             report_kind,
  input logic [POS_W-1:0] report_position,
  input logic             report_found_none
);

  logic item_xfer;

  assign item_xfer = item_valid && item_ready;

  // A stalled report keeps its payload.
  `KMPS_ASSERT_NEXT(a_report_hold, clk, rst, report_valid && !report_ready, report_valid && $stable(report_kind) && $stable(report_position) && $stable(report_found_none), "report changed while stalled")

  // A clear never produces a report.
  `KMPS_ASSERT_NEXT(a_clear_quiet, clk, rst, item_xfer && (item_op == OP_CLEAR), !$rose(report_valid), "report appeared after a clear")

  // A summary request keeps the block busy in the emit state.
  `KMPS_ASSERT_NEXT(a_end_busy, clk, rst, item_xfer && (item_op == OP_END), !item_ready, "item taken while a summary is pending")

  // A pattern byte leaves the block ready again in the cycle after it is taken.
  `KMPS_ASSERT_NEXT(a_pattern_fast, clk, rst, item_xfer && (item_op == OP_PATTERN), item_ready, "block busy after a pattern byte")

endmodule

bind k_mismatch_pattern_search kmps_port_props u_kmps_port_props (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .item_op           (item.op),
  .report_valid      (report.valid),
  .report_ready      (report.ready),
  .report_kind       (report.kind),
  .report_position   (report.position),
  .report_found_none (report.found_none)
);

>>> verif/kmps_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the k-mismatch pattern search: predicts every report and checks it.
module kmps_checker import kmps_pkg::*; #(
  parameter int MAX_PATTERN = 1024,
  parameter int MAX_TEXT    = 131072
) (
  input  logic            clk,
  input  logic            rst,
  kmps_item_if            item,
  kmps_report_if          report,
  input  logic            cfg_wr_en,
  input  logic [MM_W-1:0] cfg_wr_data,
  output int              error_count,
  output int              reports_due
);

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic             found_none;
  } search_report_t;

  // Shadow copy of the search state
  logic [SYM_W-1:0] pattern_bytes [MAX_PATTERN];
  logic [CNT_W-1:0] window_miss   [MAX_PATTERN];
  int unsigned      pattern_len = 0;
  int unsigned      text_pos    = 0;
  logic             seen_match  = 1'b0;
  logic [MM_W-1:0]  miss_limit  = MM_RESET;

  search_report_t   awaited_reports [$];
  int               errors = 0;

  function automatic void clear_search();
    pattern_len = 0;
    text_pos    = 0;
    seen_match  = 1'b0;
    foreach (window_miss[i]) window_miss[i] = '0;
  endfunction

  // Advance the shadow state by one item and queue the report it causes
  task automatic predict_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    int unsigned      j;
    int unsigned      slot;
    int unsigned      start;
    logic [CNT_W-1:0] sat;
    search_report_t   rep;
    sat = {1'b0, miss_limit} + 5'd1;
    case (op)
      OP_CLEAR: begin
        clear_search();
      end
      OP_PATTERN: begin
        // drop bytes once text has begun or the store is full
        if (text_pos == 0 && pattern_len < MAX_PATTERN) begin
          pattern_bytes[pattern_len] = sym;
          pattern_len++;
        end
      end
      OP_END: begin
        rep.kind       = KIND_SUMMARY;
        rep.position   = '0;
        rep.found_none = ~seen_match;
        awaited_reports.push_back(rep);
      end
      default: begin
        if (pattern_len != 0 && text_pos < MAX_TEXT) begin
          // a fresh alignment starts at this position
          window_miss[text_pos % pattern_len] = '0;
          for (j = 0; j < pattern_len && j <= text_pos; j++) begin
            slot = (text_pos - j) % pattern_len;
            if (sym != pattern_bytes[j] && window_miss[slot] < sat)
              window_miss[slot]++;
          end
          // report the window that this byte completes
          if (text_pos + 1 >= pattern_len) begin
            start = text_pos + 1 - pattern_len;
            if (window_miss[start % pattern_len] <= {1'b0, miss_limit}) begin
              seen_match     = 1'b1;
              rep.kind       = KIND_MATCH;
              rep.position   = start[POS_W-1:0];
              rep.found_none = 1'b0;
              awaited_reports.push_back(rep);
            end
          end
          text_pos++;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    search_report_t want;
    if (rst) begin
      miss_limit = MM_RESET;
      clear_search();
      awaited_reports.delete();
    end else begin
      if (cfg_wr_en)
        miss_limit = cfg_wr_data;

      if (item.valid && item.ready)
        predict_item(item.op, item.symbol);

      // Compare each report transfer with the oldest prediction
      if (report.valid && report.ready) begin
        if (awaited_reports.size() == 0) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display("%0t: unexpected report: expected none, actual kind=%0d position=%0d found_none=%0d",
                     $time, report.kind, report.position, report.found_none);
        end else begin
          want = awaited_reports.pop_front();
          if (report.kind !== want.kind || report.position !== want.position ||
              report.found_none !== want.found_none) begin
            errors++;
            if (errors <= PRINT_LIMIT)
              $display("%0t: report mismatch: expected kind=%0d position=%0d found_none=%0d, actual kind=%0d position=%0d found_none=%0d",
                       $time, want.kind, want.position, want.found_none,
                       report.kind, report.position, report.found_none);
          end
        end
      end
    end
    error_count <= errors;
    reports_due <= awaited_reports.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Top of the k-mismatch pattern search testbench: clock, reset, stimulus and verdict.
module testbench;
  import kmps_pkg::*;

  localparam int MAX_PATTERN   = 1024;
  localparam int MAX_TEXT      = 131072;
  localparam int RANDOM_ITEMS  = 250;
  localparam int PHASE_ITEMS   = 60;
  localparam int SETTLE_CYCLES = MAX_PATTERN + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400_000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_wr_en = 1'b0;
  logic [MM_W-1:0] cfg_wr_data = '0;
  int              error_count;
  int              reports_due;
  int              cycle_count = 0;
  int              sent_items = 0;
  bit              src_steady = 1'b0;
  bit              sink_steady = 1'b0;
  int              hold_reqs = 0;
  int              hold_seen = 0;
  int              hold_left = 0;

  kmps_item_if   item ();
  kmps_report_if report ();

  k_mismatch_pattern_search #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_TEXT   (MAX_TEXT)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .report     (report),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  kmps_checker #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_TEXT   (MAX_TEXT)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .report     (report),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .error_count(error_count),
    .reports_due(reports_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Report receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen    <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
      report.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      report.ready <= 1'b0;
    end else begin
      report.ready <= sink_steady || ($urandom_range(99) >= 10);
    end
  end

  // Offer one item, idling at random first; return at its transfer edge
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    while (!src_steady && $urandom_range(99) < 10) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid  <= 1'b1;
    item.op     <= op;
    item.symbol <= sym;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    sent_items++;
  endtask

  // Drop valid and hold until every predicted report has been transferred
  task automatic wait_reports_done();
    item.valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  task automatic set_mismatch_limit(input logic [MM_W-1:0] value);
    wait_reports_done();
    // let a trailing text byte with no report finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One well-formed case: clear, pattern, text drawn partly from the pattern with occasional summaries, final summary
  task automatic run_case(input int pat_len, input int text_len, input logic [SYM_W-1:0] mask,
                          input int copy_pct, input bit with_hold);
    logic [SYM_W-1:0] pat [$];
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] sym;
    int               i;
    base = SYM_W'($urandom);
    send_item(OP_CLEAR, SYM_W'($urandom));
    for (i = 0; i < pat_len; i++) begin
      sym = base ^ (SYM_W'($urandom) & mask);
      pat.push_back(sym);
      send_item(OP_PATTERN, sym);
    end
    if (with_hold)
      hold_reqs++;
    for (i = 0; i < text_len; i++) begin
      if (pat_len != 0 && $urandom_range(99) < copy_pct)
        sym = pat[i % pat_len];
      else
        sym = base ^ (SYM_W'($urandom) & mask);
      if ($urandom_range(99) < 3)
        send_item(OP_END, SYM_W'($urandom));
      send_item(OP_TEXT, sym);
    end
    send_item(OP_END, SYM_W'($urandom));
  endtask

  // Stimulus
  initial begin
    int               base_count;
    int               phase;
    int               pat_len;
    logic [SYM_W-1:0] mask;

    item.valid  <= 1'b0;
    item.op     <= OP_CLEAR;
    item.symbol <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // text with no pattern is ignored; summary says nothing found
    send_item(OP_TEXT, 8'h00);
    send_item(OP_END, 8'hFF);
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_PATTERN, 8'h00);
    send_item(OP_PATTERN, 8'hFF);
    send_item(OP_PATTERN, 8'h5A);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, 8'h5A);
    // pattern byte after text is dropped
    send_item(OP_PATTERN, 8'h11);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hA5);
    send_item(OP_TEXT, 8'h5A);
    send_item(OP_END, 8'h00);
    // text after the summary continues the same case
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, 8'h5A);
    send_item(OP_END, 8'h00);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_PATTERN, 8'hAA);
    send_item(OP_TEXT, 8'h55);
    send_item(OP_TEXT, 8'hAA);
    send_item(OP_END, 8'hFF);

    // pattern overflow: bytes past the store are dropped; no idling on either side
    set_mismatch_limit(4'd15);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    run_case(MAX_PATTERN + 2, 24, 8'hFF, 99, 1'b0);
    src_steady  = 1'b0;
    sink_steady = 1'b0;

    // long receiver hold-off while text keeps coming, then a full pause
    set_mismatch_limit(4'd1);
    run_case(2, 120, 8'h01, 90, 1'b1);
    wait_reports_done();

    // random cases, changing the threshold every phase
    base_count = sent_items;
    phase = 0;
    while (sent_items - base_count < RANDOM_ITEMS) begin
      if (sent_items - base_count >= phase * PHASE_ITEMS) begin
        if (phase == 0)
          set_mismatch_limit(4'd15);
        else if (phase == 1)
          set_mismatch_limit(4'd0);
        else
          set_mismatch_limit(MM_W'($urandom_range(1, 14)));
        phase++;
      end
      if ($urandom_range(99) < 12) begin
        // noise: any op, any symbol
        repeat ($urandom_range(1, 6))
          send_item(OP_W'($urandom_range(3)), SYM_W'($urandom));
      end else begin
        pat_len = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 80);
        case ($urandom_range(2))
          0:       mask = 8'h01;
          1:       mask = 8'h03;
          default: mask = 8'hFF;
        endcase
        run_case(pat_len, $urandom_range(0, 3 * pat_len + 10), mask,
                 $urandom_range(40, 95), 1'b0);
        if ($urandom_range(99) < 8)
          wait_reports_done();
      end
    end

    wait_reports_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && reports_due == 0)
      $display("[k_mismatch_pattern_search] OK");
    else
      $display("[k_mismatch_pattern_search] ERROR");
    $finish;
  end

  // Timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[k_mismatch_pattern_search] ERROR");
    $finish;
  end

endmodule

>>> k_mismatch_pattern_search.f
+incdir+hw/rtl
hw/rtl/kmps_pkg.sv
hw/rtl/kmps_item_if.sv
hw/rtl/kmps_report_if.sv
hw/rtl/kmps_ram.sv
hw/rtl/kmps_ctrl.sv
hw/rtl/kmps_dp.sv
hw/rtl/k_mismatch_pattern_search.sv
hw/rtl/kmps_checker.sv
verif/kmps_checker.sv
verif/testbench.sv
